[hdl/amb_pkg.sv]
// Package for the audio meter ballistics unit: item, result, config and state types.
// Also holds register indexes, reset values and the controller state enum. No dependencies.
package amb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q8.8 dB code that stands for minus infinity
  localparam logic signed [15:0] SILENCE = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd4;

  localparam logic [23:0]        PEAK_DECAY_RST = 24'd1343;
  localparam logic [15:0]        PEAK_HOLD_RST  = 16'd20000;
  localparam logic [15:0]        INPUT_HOLD_RST = 16'd1000;
  localparam logic [15:0]        AVG_GAIN_RST   = 16'd216;
  localparam logic signed [15:0] FLOOR_RST      = -16'sd15360;

  typedef struct packed {
    logic              action;
    logic [2:0]        channel;
    logic signed [15:0] magnitude_db;
    logic signed [15:0] peak_db;
    logic signed [15:0] input_peak_db;
    logic [31:0]       now_ms;
    logic [9:0]        elapsed_ms;
  } amb_in_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [15:0] shown_peak;
    logic signed [15:0] shown_peak_hold;
    logic signed [15:0] shown_input_hold;
    logic signed [15:0] shown_average;
  } amb_out_t;

  typedef struct packed {
    logic [23:0]        peak_decay_per_ms;
    logic [15:0]        peak_hold_ms;
    logic [15:0]        input_hold_ms;
    logic [15:0]        average_gain;
    logic signed [15:0] floor_level;
  } amb_cfg_t;

  typedef struct packed {
    logic signed [15:0] peak_level;
    logic signed [15:0] hold_level;
    logic [31:0]        hold_stamp;
    logic signed [15:0] input_hold_level;
    logic [31:0]        input_hold_stamp;
    logic signed [15:0] average_level;
  } amb_entry_t;

  localparam amb_entry_t ENTRY_RESET = '{
    peak_level:       SILENCE,
    hold_level:       SILENCE,
    hold_stamp:       32'd0,
    input_hold_level: SILENCE,
    input_hold_stamp: 32'd0,
    average_level:    SILENCE
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ROUND,
    ST_WRITE
  } amb_state_e;

endpackage

[hdl/amb_state_ram.sv]
// Per-channel meter state memory: one write port, one read port, registered read data.
// Depends on amb_pkg for the entry type.
module amb_state_ram import amb_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output amb_entry_t      rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  amb_entry_t      wr_data_i
);

  amb_entry_t mem [DEPTH];
  amb_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/amb_cfg_regs.sv]
// Configuration register file of the meter ballistics unit.
// Depends on amb_pkg for the register indexes and the config struct.
module amb_cfg_regs import amb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output amb_cfg_t              cfg_o
);

  amb_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_decay_per_ms <= PEAK_DECAY_RST;
      cfg_q.peak_hold_ms      <= PEAK_HOLD_RST;
      cfg_q.input_hold_ms     <= INPUT_HOLD_RST;
      cfg_q.average_gain      <= AVG_GAIN_RST;
      cfg_q.floor_level       <= FLOOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PEAK_DECAY: cfg_q.peak_decay_per_ms <= cfg_data_i;
        REG_PEAK_HOLD:  cfg_q.peak_hold_ms      <= cfg_data_i[15:0];
        REG_INPUT_HOLD: cfg_q.input_hold_ms     <= cfg_data_i[15:0];
        REG_AVG_GAIN:   cfg_q.average_gain      <= cfg_data_i[15:0];
        REG_FLOOR:      cfg_q.floor_level       <= $signed(cfg_data_i[15:0]);
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/audio_meter_ballistics_unit.sv]
// Top level of the audio meter ballistics unit: controller, datapath and valid bits.
// Depends on amb_pkg, amb_cfg_regs and amb_state_ram.
//
// Each transaction updates or clears one channel's meter state and yields one result with
// the channel's shown levels. Items are handled one at a time. The state RAM is read at
// acceptance, and a result is loaded into the output register once the item has passed
// the first products, gain product, rounding and write-back. The next item is accepted in
// the cycle after that, so no item starts before the last one has left write-back. A stalled
// result holds the next item in write-back. The output register lets a new item start while
// the previous result waits. Channel state comes out of reset as silence through per-channel
// valid bits, so no clearing pass runs.
module audio_meter_ballistics_unit import amb_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  amb_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output amb_out_t              out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [28:0] PEAK_MIN = -29'sd32768;

  amb_cfg_t   cfg;
  amb_state_e state_q, state_d;

  logic       in_accept;
  logic       rd_en, wr_en, out_load, out_free;

  amb_in_t           item_q;
  logic [CH_W-1:0]   addr_q;
  logic              in_range_q;
  logic [CHANNELS-1:0] valid_q;

  amb_entry_t ram_rdata, rd_entry, entry_q, wr_entry;

  logic [33:0]        decay_prod_q;
  logic signed [27:0] diff_el_q;
  logic signed [16:0] diff;
  logic signed [44:0] avg_prod_q;
  logic signed [29:0] avg_step_q, avg_step_d;

  logic signed [15:0] peak_new_q, peak_new_d;
  logic signed [15:0] hold_new_q, hold_new_d;
  logic [31:0]        stamp_new_q, stamp_new_d;
  logic signed [15:0] ihold_new_q, ihold_new_d;
  logic [31:0]        istamp_new_q, istamp_new_d;
  logic signed [15:0] avg_new;

  logic               out_valid_q;
  amb_out_t           out_item_q, out_item_d;

  amb_cfg_regs u_amb_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  amb_state_ram #(
    .DEPTH (CHANNELS),
    .AW    (CH_W)
  ) u_amb_state_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (CH_W'(in_item_i.channel)),
    .rd_data_o (ram_rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_entry)
  );

  // ---------------- controller ----------------
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_ROUND;
      ST_ROUND: state_d = ST_WRITE;
      ST_WRITE: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      ST_WRITE: out_load = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // write back only updates of channels that exist; clears just drop the valid bit
  assign wr_en = out_load && in_range_q && !item_q.action;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load && in_range_q) begin
        valid_q[addr_q] <= !item_q.action;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- accept ----------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q     <= in_item_i;
      addr_q     <= CH_W'(in_item_i.channel);
      in_range_q <= (int'(in_item_i.channel) < CHANNELS);
    end
  end

  // ---------------- read stage: first products ----------------
  assign rd_entry = (in_range_q && valid_q[addr_q]) ? ram_rdata : ENTRY_RESET;
  assign diff     = $signed({item_q.magnitude_db[15], item_q.magnitude_db})
                  - $signed({rd_entry.average_level[15], rd_entry.average_level});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      entry_q      <= rd_entry;
      decay_prod_q <= 34'(cfg.peak_decay_per_ms) * 34'(item_q.elapsed_ms);
      diff_el_q    <= 28'(diff) * 28'($signed({1'b0, item_q.elapsed_ms}));
    end
  end

  // ---------------- multiply stage: gain product, peak and holds ----------------
  logic [34:0]        decay_rnd;
  logic signed [28:0] peak_dec, peak_v, peak_lo;

  assign decay_rnd = {1'b0, decay_prod_q} + 35'd128;
  assign peak_dec  = $signed({{13{entry_q.peak_level[15]}}, entry_q.peak_level})
                   - $signed({2'b00, decay_rnd[34:8]});
  assign peak_lo   = item_q.peak_db[15]
                   ? $signed({{13{item_q.peak_db[15]}}, item_q.peak_db}) : 29'sd0;

  always_comb begin
    peak_v = peak_dec;
    if (peak_v > 29'sd0) peak_v = 29'sd0;
    if (item_q.peak_db != SILENCE && peak_v < peak_lo) peak_v = peak_lo;
    if (peak_v < PEAK_MIN) peak_v = PEAK_MIN;
    if (item_q.peak_db >= entry_q.peak_level) begin
      peak_new_d = item_q.peak_db;
    end else begin
      peak_new_d = peak_v[15:0];
    end
  end

  always_comb begin
    hold_new_d  = entry_q.hold_level;
    stamp_new_d = entry_q.hold_stamp;
    if (item_q.peak_db >= entry_q.hold_level || entry_q.hold_level == SILENCE
        || (item_q.now_ms - entry_q.hold_stamp) > {16'd0, cfg.peak_hold_ms}) begin
      hold_new_d  = item_q.peak_db;
      stamp_new_d = item_q.now_ms;
    end
    ihold_new_d  = entry_q.input_hold_level;
    istamp_new_d = entry_q.input_hold_stamp;
    if (item_q.input_peak_db >= entry_q.input_hold_level
        || entry_q.input_hold_level == SILENCE
        || (item_q.now_ms - entry_q.input_hold_stamp) > {16'd0, cfg.input_hold_ms}) begin
      ihold_new_d  = item_q.input_peak_db;
      istamp_new_d = item_q.now_ms;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      avg_prod_q   <= 45'(diff_el_q) * 45'($signed({1'b0, cfg.average_gain}));
      peak_new_q   <= peak_new_d;
      hold_new_q   <= hold_new_d;
      stamp_new_q  <= stamp_new_d;
      ihold_new_q  <= ihold_new_d;
      istamp_new_q <= istamp_new_d;
    end
  end

  // ---------------- round stage: average step, halves away from zero ----------------
  logic [44:0] avg_mag, avg_rnd;

  assign avg_mag = avg_prod_q[44] ? 45'(-avg_prod_q) : 45'(avg_prod_q);
  assign avg_rnd = avg_mag + 45'd32768;
  assign avg_step_d = avg_prod_q[44] ? -$signed({1'b0, avg_rnd[44:16]})
                                     :  $signed({1'b0, avg_rnd[44:16]});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      avg_step_q <= avg_step_d;
    end
  end

  // ---------------- write stage: average clamp, write-back, result ----------------
  logic signed [30:0] avg_sum, avg_v, floor_ext;

  assign avg_sum   = $signed({{15{entry_q.average_level[15]}}, entry_q.average_level})
                   + $signed({avg_step_q[29], avg_step_q});
  assign floor_ext = $signed({{15{cfg.floor_level[15]}}, cfg.floor_level});

  always_comb begin
    avg_v = avg_sum;
    if (avg_v < floor_ext) avg_v = floor_ext;
    if (avg_v > 31'sd0) avg_v = 31'sd0;
    if (entry_q.average_level == SILENCE) begin
      avg_new = item_q.magnitude_db;
    end else if (item_q.magnitude_db == SILENCE) begin
      avg_new = cfg.floor_level;
    end else begin
      avg_new = avg_v[15:0];
    end
  end

  always_comb begin
    wr_entry.peak_level       = peak_new_q;
    wr_entry.hold_level       = hold_new_q;
    wr_entry.hold_stamp       = stamp_new_q;
    wr_entry.input_hold_level = ihold_new_q;
    wr_entry.input_hold_stamp = istamp_new_q;
    wr_entry.average_level    = avg_new;
  end

  always_comb begin
    out_item_d.out_channel = item_q.channel;
    if (!in_range_q || item_q.action) begin
      out_item_d.shown_peak       = SILENCE;
      out_item_d.shown_peak_hold  = SILENCE;
      out_item_d.shown_input_hold = SILENCE;
      out_item_d.shown_average    = SILENCE;
    end else begin
      out_item_d.shown_peak       = peak_new_q;
      out_item_d.shown_peak_hold  = hold_new_q;
      out_item_d.shown_input_hold = ihold_new_q;
      out_item_d.shown_average    = avg_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hdl/amb_checker.sv]
// Port-level checks for the audio meter ballistics unit, bound to the top level.
// Depends on amb_pkg for the result type.
module amb_checker import amb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input amb_out_t out_item_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // an accepted transaction keeps the input closed through its read-modify-write
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input reopened before write-back");

  // a new result only appears as a transaction finishes
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in flight");

endmodule

bind audio_meter_ballistics_unit amb_checker u_amb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[sim/audio_meter_ballistics_unit_tb.sv]
// Self-checking testbench for audio_meter_ballistics_unit: directed table, then random traffic.
// Per-channel levels are predicted in the bench and checked in order on every result transaction.
// Depends on amb_pkg and the audio_meter_ballistics_unit RTL.
module audio_meter_ballistics_unit_tb;
  import amb_pkg::*;

  localparam int N_CH            = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 12;
  localparam int BACKLOG_CYCLES  = 400;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    amb_in_t  item;
    logic     known;
    amb_out_t levels;
  } script_row_t;

  typedef struct packed {
    logic [23:0]        decay;
    logic [15:0]        peak_hold;
    logic [15:0]        input_hold;
    logic [15:0]        gain;
    logic signed [15:0] floor_lvl;
  } meter_settings_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  amb_in_t               in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  amb_out_t              out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // register mirror
  logic [23:0]        cfg_decay      = PEAK_DECAY_RST;
  logic [15:0]        cfg_peak_hold  = PEAK_HOLD_RST;
  logic [15:0]        cfg_input_hold = INPUT_HOLD_RST;
  logic [15:0]        cfg_gain       = AVG_GAIN_RST;
  logic signed [15:0] cfg_floor      = FLOOR_RST;

  // per-channel meter state
  logic signed [15:0] chan_peak          [N_CH];
  logic signed [15:0] chan_hold          [N_CH];
  logic [31:0]        chan_hold_at       [N_CH];
  logic signed [15:0] chan_input_hold    [N_CH];
  logic [31:0]        chan_input_hold_at [N_CH];
  logic signed [15:0] chan_average       [N_CH];

  amb_out_t shown_levels_q[$];

  logic [31:0] clock_ms = '0;
  int items_sent     = 0;
  int clears_sent    = 0;
  int results_seen   = 0;
  int faults         = 0;
  int settings_used  = 1;

  audio_meter_ballistics_unit #(
    .CHANNELS(N_CH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", shown_levels_q.size());
    $display("audio_meter_ballistics_unit regression: fail");
    $finish;
  end

  function automatic void hold_step(inout logic signed [15:0] lvl, inout logic [31:0] at,
                                    input logic signed [15:0] cur, input logic [31:0] now,
                                    input logic [15:0] span);
    logic [31:0] age;
    age = now - at;
    if (cur >= lvl || lvl == SILENCE || age > span) begin
      lvl = cur;
      at  = now;
    end
  endfunction

  function automatic amb_out_t advance_meter(amb_in_t it);
    amb_out_t res;
    int       c;
    longint   fall, v, lo, prod, step;
    c = int'(it.channel);
    if (it.action == ACT_CLEAR) begin
      chan_peak[c]          = SILENCE;
      chan_hold[c]          = SILENCE;
      chan_hold_at[c]       = '0;
      chan_input_hold[c]    = SILENCE;
      chan_input_hold_at[c] = '0;
      chan_average[c]       = SILENCE;
    end else begin
      if (it.peak_db >= chan_peak[c]) begin
        chan_peak[c] = it.peak_db;
      end else begin
        fall = (longint'(cfg_decay) * longint'(it.elapsed_ms) + 128) >>> 8;
        v = longint'(chan_peak[c]) - fall;
        // a silent peak puts no lower bound on the fall
        if (it.peak_db != SILENCE) begin
          lo = (it.peak_db < 0) ? longint'(it.peak_db) : 0;
          if (v < lo) v = lo;
        end
        if (v > 0) v = 0;
        if (v < -32768) v = -32768;
        chan_peak[c] = 16'(v);
      end

      hold_step(chan_hold[c], chan_hold_at[c], it.peak_db, it.now_ms, cfg_peak_hold);
      hold_step(chan_input_hold[c], chan_input_hold_at[c], it.input_peak_db, it.now_ms,
                cfg_input_hold);

      if (chan_average[c] == SILENCE) begin
        chan_average[c] = it.magnitude_db;
      end else if (it.magnitude_db == SILENCE) begin
        chan_average[c] = cfg_floor;
      end else begin
        prod = (longint'(it.magnitude_db) - longint'(chan_average[c])) *
               longint'(it.elapsed_ms) * longint'(cfg_gain);
        // round half away from zero
        step = (prod >= 0) ? ((prod + 32768) >>> 16) : -((32768 - prod) >>> 16);
        v = longint'(chan_average[c]) + step;
        if (v < longint'(cfg_floor)) v = longint'(cfg_floor);
        if (v > 0) v = 0;
        chan_average[c] = 16'(v);
      end
    end
    res.out_channel      = it.channel;
    res.shown_peak       = chan_peak[c];
    res.shown_peak_hold  = chan_hold[c];
    res.shown_input_hold = chan_input_hold[c];
    res.shown_average    = chan_average[c];
    return res;
  endfunction

  function automatic amb_in_t item_of(logic act, int ch, int mag, int pk, int ipk,
                                      logic [31:0] now, int el);
    amb_in_t it;
    it.action        = act;
    it.channel       = 3'(ch);
    it.magnitude_db  = 16'(mag);
    it.peak_db       = 16'(pk);
    it.input_peak_db = 16'(ipk);
    it.now_ms        = now;
    it.elapsed_ms    = 10'(el);
    return it;
  endfunction

  function automatic amb_out_t shows(int ch, int pk, int hold, int ihold, int avg);
    amb_out_t r;
    r.out_channel      = 3'(ch);
    r.shown_peak       = 16'(pk);
    r.shown_peak_hold  = 16'(hold);
    r.shown_input_hold = 16'(ihold);
    r.shown_average    = 16'(avg);
    return r;
  endfunction

  function automatic logic signed [15:0] random_level();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) return SILENCE;
    if (roll < 15) return 16'sd32767;
    if (roll < 20) return -16'sd32767;
    if (roll < 70) return 16'(-$urandom_range(15360, 0));
    if (roll < 80) return 16'($urandom_range(1536, 0));
    return 16'($urandom);
  endfunction

  // mostly ordinary meter updates with advancing time; rare clears and clock jumps
  function automatic amb_in_t next_random_item();
    amb_in_t it;
    int      roll;
    it.action        = ($urandom_range(99, 0) < 4) ? ACT_CLEAR : ACT_UPDATE;
    it.channel       = 3'($urandom_range(7, 0));
    it.magnitude_db  = random_level();
    it.peak_db       = random_level();
    it.input_peak_db = random_level();
    roll = $urandom_range(99, 0);
    if (roll < 55)      it.elapsed_ms = 10'($urandom_range(40, 0));
    else if (roll < 80) it.elapsed_ms = 10'($urandom);
    else if (roll < 90) it.elapsed_ms = '0;
    else                it.elapsed_ms = '1;
    clock_ms = clock_ms + 32'(it.elapsed_ms);
    if ($urandom_range(99, 0) < 3) clock_ms = $urandom;
    it.now_ms = clock_ms;
    return it;
  endfunction

  task automatic push_item(input amb_in_t it, input logic known, input amb_out_t levels);
    amb_out_t predicted;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_meter(it);
    shown_levels_q.push_back(known ? levels : predicted);
    items_sent++;
    if (it.action == ACT_CLEAR) clears_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PEAK_DECAY: cfg_decay      = data[23:0];
      REG_PEAK_HOLD:  cfg_peak_hold  = data[15:0];
      REG_INPUT_HOLD: cfg_input_hold = data[15:0];
      REG_AVG_GAIN:   cfg_gain       = data[15:0];
      REG_FLOOR:      cfg_floor      = data[15:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    while (shown_levels_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_side
    amb_out_t want;
    int       mode_left;
    int       stall_pct;
    int       hold_left;
    logic     backlog_done;
    mode_left    = 0;
    stall_pct    = 0;
    hold_left    = 0;
    backlog_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (shown_levels_q.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result transaction for channel %0d", out_item_o.out_channel);
        end else begin
          want = shown_levels_q.pop_front();
          if (out_item_o.out_channel !== want.out_channel ||
              out_item_o.shown_peak !== want.shown_peak ||
              out_item_o.shown_peak_hold !== want.shown_peak_hold ||
              out_item_o.shown_input_hold !== want.shown_input_hold ||
              out_item_o.shown_average !== want.shown_average) begin
            faults++;
            if (faults <= 10)
              $display({"mismatch: expected ch %0d pk %0d hold %0d in %0d avg %0d, ",
                        "got ch %0d pk %0d hold %0d in %0d avg %0d"},
                       want.out_channel, want.shown_peak, want.shown_peak_hold,
                       want.shown_input_hold, want.shown_average,
                       out_item_o.out_channel, out_item_o.shown_peak,
                       out_item_o.shown_peak_hold, out_item_o.shown_input_hold,
                       out_item_o.shown_average);
          end
        end
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(80, 10);
        case ($urandom_range(3, 0))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      // hold off once for a long stretch so the block backs up into its input
      if (results_seen >= 200 && !backlog_done) begin
        hold_left    = BACKLOG_CYCLES;
        backlog_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    script_row_t     script[$];
    meter_settings_t settings_plan[5];
    meter_settings_t s;
    int              burst_left;
    int              gap;
    int              directed;
    logic            steady;

    for (int c = 0; c < N_CH; c++) begin
      chan_peak[c]          = SILENCE;
      chan_hold[c]          = SILENCE;
      chan_hold_at[c]       = '0;
      chan_input_hold[c]    = SILENCE;
      chan_input_hold_at[c] = '0;
      chan_average[c]       = SILENCE;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values throughout the table
    script.push_back('{item_of(ACT_UPDATE, 0, 0, 0, 0, 32'd100, 0), 1'b1,
                       shows(0, 0, 0, 0, 0)});
    script.push_back('{item_of(ACT_UPDATE, 0, SILENCE, SILENCE, SILENCE, 32'd110, 10),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 1, 32767, 32767, 32767, 32'd120, 1023), 1'b1,
                       shows(1, 32767, 32767, 32767, 32767)});
    script.push_back('{item_of(ACT_UPDATE, 1, -32767, -32767, -32767, 32'd130, 1023),
                       1'b0, '0});
    script.push_back('{item_of(ACT_CLEAR, 1, 1234, -5, 77, 32'd140, 3), 1'b1,
                       shows(1, SILENCE, SILENCE, SILENCE, SILENCE)});
    // hold stamps straddle the timestamp wrap
    script.push_back('{item_of(ACT_UPDATE, 2, SILENCE, SILENCE, SILENCE, 32'hFFFF_FFF0, 0),
                       1'b1, shows(2, SILENCE, SILENCE, SILENCE, SILENCE)});
    script.push_back('{item_of(ACT_UPDATE, 2, -2560, -256, -512, 32'hFFFF_FFF8, 8), 1'b1,
                       shows(2, -256, -256, -512, -2560)});
    script.push_back('{item_of(ACT_UPDATE, 2, -2000, -3000, -3000, 32'h0000_0010, 18),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 2, -2100, -3100, -3100, 32'h0000_03E0, 1023),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 2, -2200, -3200, -3200, 32'h0000_03E1, 1),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 3, -100, 0, 0, 32'd200, 0), 1'b1,
                       shows(3, 0, 0, 0, -100)});
    script.push_back('{item_of(ACT_UPDATE, 3, -100, SILENCE, SILENCE, 32'd210, 1023),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 3, -100, -32767, -32767, 32'd220, 1023),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 3, -100, -100, -100, 32'd230, 1023), 1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 4, -50, 300, 300, 32'd300, 0), 1'b1,
                       shows(4, 300, 300, 300, -50)});
    script.push_back('{item_of(ACT_UPDATE, 4, -50, 100, 100, 32'd301, 1), 1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 5, -32767, -32767, -32767, 32'd400, 0), 1'b1,
                       shows(5, -32767, -32767, -32767, -32767)});
    script.push_back('{item_of(ACT_UPDATE, 5, 32767, 32767, 32767, 32'd401, 1023),
                       1'b0, '0});
    script.push_back('{item_of(ACT_UPDATE, 5, SILENCE, SILENCE, SILENCE, 32'd402, 1),
                       1'b0, '0});
    script.push_back('{item_of(ACT_CLEAR, 7, 32767, 32767, 32767, 32'hFFFF_FFFF, 1023), 1'b1,
                       shows(7, SILENCE, SILENCE, SILENCE, SILENCE)});
    script.push_back('{item_of(ACT_UPDATE, 6, 32767, -1, 32767, 32'hFFFF_FFFF, 1023), 1'b1,
                       shows(6, -1, -1, 32767, 32767)});
    script.push_back('{item_of(ACT_UPDATE, 6, -1, -2, -1, 32'h0000_0000, 1023), 1'b0, '0});

    foreach (script[i]) push_item(script[i].item, script[i].known, script[i].levels);
    directed = script.size();
    in_valid_i <= 1'b0;
    settle();

    settings_plan[0] = '{24'hFF_FFFF, 16'd0, 16'd0, 16'hFFFF, -16'sd32767};
    settings_plan[1] = '{24'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'sd0};
    // floor at minus infinity lets the average fall back to silence
    settings_plan[2] = '{24'd700, 16'd300, 16'd50, 16'd2000, SILENCE};
    // a positive floor loses to the zero ceiling, except that a silent input sets the average to it
    settings_plan[3] = '{24'd5000, 16'd2000, 16'd100, 16'd20000, 16'sd256};
    settings_plan[4] = '{24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'(-$urandom_range(32767, 0))};

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        s = settings_plan[ph-1];
        write_reg(REG_PEAK_DECAY, s.decay);
        write_reg(REG_PEAK_HOLD,  {8'($urandom), s.peak_hold});
        write_reg(REG_INPUT_HOLD, {8'($urandom), s.input_hold});
        write_reg(REG_AVG_GAIN,   {8'($urandom), s.gain});
        write_reg(REG_FLOOR,      {8'($urandom), s.floor_lvl});
        if (ph == 5) write_reg(REG_UNUSED, 24'($urandom));
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
        settings_used++;
      end
      if (ph == 3) clock_ms = 32'hFFFF_F000;
      steady     = (ph == 2);
      burst_left = 0;
      repeat (ITEMS_PER_PHASE) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          gap = steady ? 0 : $urandom_range(10, 0);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        push_item(next_random_item(), 1'b0, '0);
        burst_left--;
      end
      in_valid_i <= 1'b0;
      settle();
    end

    $display("%0d transactions (%0d directed, %0d clears) over %0d register settings,",
             items_sent, directed, clears_sent, settings_used);
    $display("%0d results checked in order", results_seen);
    if (faults == 0 && shown_levels_q.size() == 0) begin
      $display("audio_meter_ballistics_unit regression: pass");
    end else begin
      $display("%0d failures", faults + shown_levels_q.size());
      $display("audio_meter_ballistics_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/amb_pkg.sv
hdl/amb_state_ram.sv
hdl/amb_cfg_regs.sv
hdl/audio_meter_ballistics_unit.sv
hdl/amb_checker.sv
sim/audio_meter_ballistics_unit_tb.sv
